// ----- hdl/cwsik_pkg.sv -----
// Shared constants and types for the wheel speed inverse kinematics unit.
package cwsik_pkg;

  // Output saturation width (signed); valid range 12..32
  localparam int DATA_WIDTH = 16;

  // Fixed field widths
  localparam int IN_W    = 16;  // Q4.12 velocity command
  localparam int LEN_W   = 16;  // Q2.14 length
  localparam int REC_W   = 16;  // Q8.8 reciprocal
  localparam int SPD_W   = 16;  // Q8.8 wheel speed
  localparam int DB_W    = 15;  // deadband magnitude
  localparam int MODE_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int APB_W   = 32;

  // Internal datapath widths
  localparam int X_W        = IN_W + 15;          // velocity at scale 2^27
  localparam int LSUM_W     = LEN_W + 1;          // base + track
  localparam int ROT_W      = IN_W + LSUM_W + 1;  // signed rotation term
  localparam int LIN_W      = ROT_W + 1;          // wheel linear velocity
  localparam int PROD_W     = LIN_W + REC_W + 1;  // times reciprocal
  localparam int FRAC_SHIFT = 27;
  localparam int SHR_W      = PROD_W - FRAC_SHIFT;
  localparam int CMP_W      = ((DATA_WIDTH > SHR_W) ? DATA_WIDTH : SHR_W) + 1;

  localparam logic signed [CMP_W-1:0] SAT_HI =
    CMP_W'((longint'(1) <<< (DATA_WIDTH - 1)) - longint'(1));
  localparam logic signed [CMP_W-1:0] SAT_LO =
    CMP_W'(-(longint'(1) <<< (DATA_WIDTH - 1)));

  // Chassis modes
  typedef enum logic [MODE_W-1:0] {
    MODE_MECANUM  = 2'd0,
    MODE_DIFF     = 2'd1,
    MODE_STANDARD = 2'd2,
    MODE_ALT_MEC  = 2'd3
  } mode_e;

  // Register map (word index)
  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_BASE      = 3'd1,
    REG_TRACK     = 3'd2,
    REG_INV_CIRC  = 3'd3,
    REG_INV_RAD   = 3'd4,
    REG_MAX_SPEED = 3'd5,
    REG_MIN_SPEED = 3'd6,
    REG_DEADBAND  = 3'd7
  } reg_idx_e;

  // Reset values
  localparam logic [REC_W-1:0]        RST_INV_CIRC  = 16'd818;
  localparam logic [REC_W-1:0]        RST_INV_RAD   = 16'd5120;
  localparam logic signed [SPD_W-1:0] RST_MAX_SPEED = 16'sh7FFF;
  localparam logic signed [SPD_W-1:0] RST_MIN_SPEED = 16'sh8000;
  localparam logic [DB_W-1:0]         RST_DEADBAND  = 15'd4;

  // Zero a command whose magnitude is below the deadband
  function automatic logic signed [IN_W-1:0] apply_db(
    input logic signed [IN_W-1:0] v,
    input logic [DB_W-1:0]        db
  );
    logic signed [IN_W:0] ext;
    logic [IN_W:0]        mag;
    ext = {v[IN_W-1], v};
    mag = v[IN_W-1] ? unsigned'(-ext) : unsigned'(ext);
    return (mag < {2'b00, db}) ? '0 : v;
  endfunction

endpackage

// ----- hdl/chassis_wheel_speed_ik_unit.sv -----
// Top level: pipelined inverse kinematics from body velocity to four wheel speeds.
//
// Issue start with the three velocity fields; busy stays low, so a command is
// taken every clock. Each command yields one set of four wheel speeds on
// done_o after passing the stages in order (deadband, rotation multiply, wheel sums,
// reciprocal multiply, saturate/clamp), one register stage each; the result
// is shown for a single cycle and is not held. Mode, geometry, reciprocals,
// limits and deadband sit on the APB port and should only be written while
// no command is in flight. A zero reciprocal gives zero speeds if the limits admit zero.
module chassis_wheel_speed_ik_unit
  import cwsik_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic signed [IN_W-1:0]   vel_fwd_i,
  input  logic signed [IN_W-1:0]   vel_lat_i,
  input  logic signed [IN_W-1:0]   yaw_rate_i,
  // result channel
  output logic                     done_o,
  output logic signed [SPD_W-1:0]  speed_left_front_o,
  output logic signed [SPD_W-1:0]  speed_right_front_o,
  output logic signed [SPD_W-1:0]  speed_left_rear_o,
  output logic signed [SPD_W-1:0]  speed_right_rear_o,
  // APB configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [APB_W-1:0]         pwdata,
  output logic [APB_W-1:0]         prdata,
  output logic                     pready
);

  // Configuration registers
  logic [MODE_W-1:0]        mode_q;
  logic [LEN_W-1:0]         base_q;
  logic [LEN_W-1:0]         track_q;
  logic [REC_W-1:0]         inv_circ_q;
  logic [REC_W-1:0]         inv_rad_q;
  logic signed [SPD_W-1:0]  max_speed_q;
  logic signed [SPD_W-1:0]  min_speed_q;
  logic [DB_W-1:0]          deadband_q;

  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_MECANUM;
      base_q      <= '0;
      track_q     <= '0;
      inv_circ_q  <= RST_INV_CIRC;
      inv_rad_q   <= RST_INV_RAD;
      max_speed_q <= RST_MAX_SPEED;
      min_speed_q <= RST_MIN_SPEED;
      deadband_q  <= RST_DEADBAND;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:      mode_q      <= pwdata[MODE_W-1:0];
        REG_BASE:      base_q      <= pwdata[LEN_W-1:0];
        REG_TRACK:     track_q     <= pwdata[LEN_W-1:0];
        REG_INV_CIRC:  inv_circ_q  <= pwdata[REC_W-1:0];
        REG_INV_RAD:   inv_rad_q   <= pwdata[REC_W-1:0];
        REG_MAX_SPEED: max_speed_q <= pwdata[SPD_W-1:0];
        REG_MIN_SPEED: min_speed_q <= pwdata[SPD_W-1:0];
        REG_DEADBAND:  deadband_q  <= pwdata[DB_W-1:0];
        default:       ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_MODE:      prdata = APB_W'(mode_q);
      REG_BASE:      prdata = APB_W'(base_q);
      REG_TRACK:     prdata = APB_W'(track_q);
      REG_INV_CIRC:  prdata = APB_W'(inv_circ_q);
      REG_INV_RAD:   prdata = APB_W'(inv_rad_q);
      REG_MAX_SPEED: prdata = {{(APB_W-SPD_W){max_speed_q[SPD_W-1]}}, max_speed_q};
      REG_MIN_SPEED: prdata = {{(APB_W-SPD_W){min_speed_q[SPD_W-1]}}, min_speed_q};
      REG_DEADBAND:  prdata = APB_W'(deadband_q);
      default:       prdata = '0;
    endcase
  end

  // Mode decode; differential is the mecanum form with vy = 0 and L = base
  logic              is_diff;
  logic              drop_y;
  logic [LSUM_W-1:0] len_sel;
  logic [REC_W-1:0]  rec_sel;

  assign is_diff = (mode_q == MODE_DIFF);
  assign drop_y  = is_diff | (mode_q == MODE_STANDARD);
  assign len_sel = is_diff ? {1'b0, base_q} : ({1'b0, base_q} + {1'b0, track_q});
  assign rec_sel = is_diff ? inv_rad_q : inv_circ_q;

  // Stage 1: deadband
  logic                   v1_q;
  logic signed [IN_W-1:0] vx1_q, vy1_q, wz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start & ~busy;
  end

  always_ff @(posedge clk_i) begin
    vx1_q <= apply_db(vel_fwd_i, deadband_q);
    vy1_q <= apply_db(vel_lat_i, deadband_q);
    wz1_q <= apply_db(yaw_rate_i, deadband_q);
  end

  // Stage 2: scale linear terms, rotation multiply
  logic                    v2_q;
  logic signed [X_W-1:0]   x2_q, y2_q;
  logic signed [ROT_W-1:0] rot2_q;
  logic signed [LSUM_W:0]  len_s;

  assign len_s = {1'b0, len_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    x2_q   <= {vx1_q, 15'd0};
    y2_q   <= drop_y ? '0 : {vy1_q, 15'd0};
    rot2_q <= ROT_W'(wz1_q * len_s);
  end

  // Stage 3: per-wheel linear velocity
  logic                    v3_q;
  logic signed [LIN_W-1:0] lin3_q [4];
  logic signed [LIN_W-1:0] xe, ye, re;

  assign xe = {{(LIN_W-X_W){x2_q[X_W-1]}}, x2_q};
  assign ye = {{(LIN_W-X_W){y2_q[X_W-1]}}, y2_q};
  assign re = {{(LIN_W-ROT_W){rot2_q[ROT_W-1]}}, rot2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    lin3_q[0] <= xe - ye - re;  // left front
    lin3_q[1] <= xe + ye + re;  // right front
    lin3_q[2] <= xe + ye - re;  // left rear
    lin3_q[3] <= xe - ye + re;  // right rear
  end

  // Stage 4: reciprocal multiply
  logic                     v4_q;
  logic signed [PROD_W-1:0] prod4_q [4];
  logic signed [REC_W:0]    rec_s;

  assign rec_s = {1'b0, rec_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      prod4_q[i] <= PROD_W'(lin3_q[i] * rec_s);
    end
  end

  // Stage 5: floor shift, saturate, clamp
  logic                    v5_q;
  logic signed [SPD_W-1:0] spd5_q [4];
  logic signed [SPD_W-1:0] spd5_d [4];
  logic signed [CMP_W-1:0] max_e, min_e;

  assign max_e = {{(CMP_W-SPD_W){max_speed_q[SPD_W-1]}}, max_speed_q};
  assign min_e = {{(CMP_W-SPD_W){min_speed_q[SPD_W-1]}}, min_speed_q};

  always_comb begin
    logic signed [PROD_W-1:0] shr;
    logic signed [CMP_W-1:0]  v;
    for (int i = 0; i < 4; i++) begin
      shr = prod4_q[i] >>> FRAC_SHIFT;
      v   = {{(CMP_W-SHR_W){shr[SHR_W-1]}}, shr[SHR_W-1:0]};
      if (v > SAT_HI) v = SAT_HI;
      if (v < SAT_LO) v = SAT_LO;
      if (v > max_e)  v = max_e;
      if (v < min_e)  v = min_e;
      spd5_d[i] = v[SPD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      spd5_q[i] <= spd5_d[i];
    end
  end

  // Outputs
  assign done_o              = v5_q;
  assign speed_left_front_o  = spd5_q[0];
  assign speed_right_front_o = spd5_q[1];
  assign speed_left_rear_o   = spd5_q[2];
  assign speed_right_rear_o  = spd5_q[3];

endmodule

// ----- sim/chassis_wheel_speed_ik_unit_check.sv -----
// Checker for the wheel speed unit: tracks the register file, predicts wheel speeds, compares.
module chassis_wheel_speed_ik_unit_check
  import cwsik_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic signed [IN_W-1:0]  vel_fwd_i,
  input  logic signed [IN_W-1:0]  vel_lat_i,
  input  logic signed [IN_W-1:0]  yaw_rate_i,
  input  logic                    done_i,
  input  logic signed [SPD_W-1:0] speed_left_front_i,
  input  logic signed [SPD_W-1:0] speed_right_front_i,
  input  logic signed [SPD_W-1:0] speed_left_rear_i,
  input  logic signed [SPD_W-1:0] speed_right_rear_i,
  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic [ADDR_W-1:0]       paddr_i,
  input  logic [APB_W-1:0]        pwdata_i,
  input  logic                    pready_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Wheel velocity sits at scale 2^35 after the reciprocal multiply
  localparam int SCALE_SHIFT = 27;

  typedef struct {
    logic signed [SPD_W-1:0] lf;
    logic signed [SPD_W-1:0] rf;
    logic signed [SPD_W-1:0] lr;
    logic signed [SPD_W-1:0] rr;
  } wheel_set_t;

  // Shadow copy of the register file
  mode_e                   cfg_mode;
  logic [LEN_W-1:0]        cfg_base;
  logic [LEN_W-1:0]        cfg_track;
  logic [REC_W-1:0]        cfg_inv_circ;
  logic [REC_W-1:0]        cfg_inv_rad;
  logic signed [SPD_W-1:0] cfg_max_spd;
  logic signed [SPD_W-1:0] cfg_min_spd;
  logic [DB_W-1:0]         cfg_db;

  wheel_set_t speeds_due[$];
  int         mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
    fail_count_o = mismatches;
  endtask

  task automatic check_speed(input string wheel, input logic signed [SPD_W-1:0] want,
                             input logic signed [SPD_W-1:0] got);
    if (got !== want) begin
      report_mismatch($sformatf("%s speed: got %0d, want %0d", wheel, got, want));
    end
  endtask

  // Commands with magnitude below the deadband become zero (|-32768| is 32768)
  function automatic longint gate_deadband(input logic signed [IN_W-1:0] v);
    longint mag;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    return (mag < longint'(cfg_db)) ? 0 : longint'(v);
  endfunction

  // Reciprocal multiply, floor shift, saturate to DATA_WIDTH, clamp to limits
  function automatic logic signed [SPD_W-1:0] scale_clamp(input longint lin,
                                                          input logic [REC_W-1:0] recip);
    longint v;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo = -(longint'(1) <<< (DATA_WIDTH - 1));
    v  = (lin * longint'(recip)) >>> SCALE_SHIFT;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    if (v > longint'(cfg_max_spd)) v = longint'(cfg_max_spd);
    if (v < longint'(cfg_min_spd)) v = longint'(cfg_min_spd);
    return SPD_W'(v);
  endfunction

  function automatic wheel_set_t predict_wheel_speeds(input logic signed [IN_W-1:0] x_cmd,
                                                      input logic signed [IN_W-1:0] y_cmd,
                                                      input logic signed [IN_W-1:0] z_cmd);
    wheel_set_t res;
    longint     vx;
    longint     vy;
    longint     wz;
    longint     x;
    longint     y;
    longint     rot;
    vx = gate_deadband(x_cmd);
    vy = gate_deadband(y_cmd);
    wz = gate_deadband(z_cmd);
    x  = vx * 32768;
    if (cfg_mode == MODE_DIFF) begin
      // left and right sides, mirrored front to rear
      rot    = wz * longint'(cfg_base);
      res.lf = scale_clamp(x - rot, cfg_inv_rad);
      res.rf = scale_clamp(x + rot, cfg_inv_rad);
      res.lr = res.lf;
      res.rr = res.rf;
    end else begin
      // mecanum; standard drops the lateral term
      y      = (cfg_mode == MODE_STANDARD) ? 0 : vy * 32768;
      rot    = wz * (longint'(cfg_base) + longint'(cfg_track));
      res.lf = scale_clamp(x - y - rot, cfg_inv_circ);
      res.rf = scale_clamp(x + y + rot, cfg_inv_circ);
      res.lr = scale_clamp(x + y - rot, cfg_inv_circ);
      res.rr = scale_clamp(x - y + rot, cfg_inv_circ);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_set_t want;
    if (!rst_ni) begin
      cfg_mode     = MODE_MECANUM;
      cfg_base     = '0;
      cfg_track    = '0;
      cfg_inv_circ = RST_INV_CIRC;
      cfg_inv_rad  = RST_INV_RAD;
      cfg_max_spd  = RST_MAX_SPEED;
      cfg_min_spd  = RST_MIN_SPEED;
      cfg_db       = RST_DEADBAND;
      speeds_due.delete();
    end else begin
      // register write on the access cycle
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[ADDR_W-1:2]))
          REG_MODE:      cfg_mode     = mode_e'(pwdata_i[MODE_W-1:0]);
          REG_BASE:      cfg_base     = pwdata_i[LEN_W-1:0];
          REG_TRACK:     cfg_track    = pwdata_i[LEN_W-1:0];
          REG_INV_CIRC:  cfg_inv_circ = pwdata_i[REC_W-1:0];
          REG_INV_RAD:   cfg_inv_rad  = pwdata_i[REC_W-1:0];
          REG_MAX_SPEED: cfg_max_spd  = pwdata_i[SPD_W-1:0];
          REG_MIN_SPEED: cfg_min_spd  = pwdata_i[SPD_W-1:0];
          REG_DEADBAND:  cfg_db       = pwdata_i[DB_W-1:0];
          default: ;
        endcase
      end
      // result against the oldest prediction
      if (done_i) begin
        if (speeds_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d %0d %0d %0d",
                                    speed_left_front_i, speed_right_front_i,
                                    speed_left_rear_i, speed_right_rear_i));
        end else begin
          want = speeds_due.pop_front();
          check_speed("left front", want.lf, speed_left_front_i);
          check_speed("right front", want.rf, speed_right_front_i);
          check_speed("left rear", want.lr, speed_left_rear_i);
          check_speed("right rear", want.rr, speed_right_rear_i);
        end
      end
      // accepted command
      if (start_i && !busy_i) begin
        speeds_due.push_back(predict_wheel_speeds(vel_fwd_i, vel_lat_i, yaw_rate_i));
      end
    end
    pending_o = speeds_due.size();
  end

endmodule

// ----- sim/chassis_wheel_speed_ik_unit_test.sv -----
// Testbench top for the wheel speed unit: clock, reset, register setup and command stimulus.
module chassis_wheel_speed_ik_unit_test;
  import cwsik_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_CMDS  = 180;

  typedef struct {
    mode_e                   mode;
    logic [LEN_W-1:0]        base;
    logic [LEN_W-1:0]        track;
    logic [REC_W-1:0]        inv_circ;
    logic [REC_W-1:0]        inv_rad;
    logic signed [SPD_W-1:0] max_spd;
    logic signed [SPD_W-1:0] min_spd;
    logic [DB_W-1:0]         db;
  } chassis_cfg_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    start       = 1'b0;
  logic                    busy;
  logic signed [IN_W-1:0]  vel_fwd     = '0;
  logic signed [IN_W-1:0]  vel_lat     = '0;
  logic signed [IN_W-1:0]  yaw_rate    = '0;
  logic                    done;
  logic signed [SPD_W-1:0] speed_lf;
  logic signed [SPD_W-1:0] speed_rf;
  logic signed [SPD_W-1:0] speed_lr;
  logic signed [SPD_W-1:0] speed_rr;
  logic                    psel        = 1'b0;
  logic                    penable     = 1'b0;
  logic                    pwrite      = 1'b0;
  logic [ADDR_W-1:0]       paddr       = '0;
  logic [APB_W-1:0]        pwdata      = '0;
  logic [APB_W-1:0]        prdata;
  logic                    pready;
  int                      fail_count;
  int                      pending;
  int                      cycles      = 0;
  int                      burst_left  = 0;
  int                      cur_db      = int'(RST_DEADBAND);
  chassis_cfg_t            cfg;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  chassis_wheel_speed_ik_unit u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .vel_fwd_i           (vel_fwd),
    .vel_lat_i           (vel_lat),
    .yaw_rate_i          (yaw_rate),
    .done_o              (done),
    .speed_left_front_o  (speed_lf),
    .speed_right_front_o (speed_rf),
    .speed_left_rear_o   (speed_lr),
    .speed_right_rear_o  (speed_rr),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  chassis_wheel_speed_ik_unit_check u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start),
    .busy_i              (busy),
    .vel_fwd_i           (vel_fwd),
    .vel_lat_i           (vel_lat),
    .yaw_rate_i          (yaw_rate),
    .done_i              (done),
    .speed_left_front_i  (speed_lf),
    .speed_right_front_i (speed_rf),
    .speed_left_rear_i   (speed_lr),
    .speed_right_rear_i  (speed_rr),
    .psel_i              (psel),
    .penable_i           (penable),
    .pwrite_i            (pwrite),
    .paddr_i             (paddr),
    .pwdata_i            (pwdata),
    .pready_i            (pready),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Setup and access cycle, then the bus returns to idle
  task automatic apb_write(input reg_idx_e idx, input logic [APB_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input chassis_cfg_t c);
    apb_write(REG_MODE, APB_W'(c.mode));
    apb_write(REG_BASE, APB_W'(c.base));
    apb_write(REG_TRACK, APB_W'(c.track));
    apb_write(REG_INV_CIRC, APB_W'(c.inv_circ));
    apb_write(REG_INV_RAD, APB_W'(c.inv_rad));
    apb_write(REG_MAX_SPEED, {{(APB_W-SPD_W){c.max_spd[SPD_W-1]}}, c.max_spd});
    apb_write(REG_MIN_SPEED, {{(APB_W-SPD_W){c.min_spd[SPD_W-1]}}, c.min_spd});
    apb_write(REG_DEADBAND, APB_W'(c.db));
    cur_db = int'(c.db);
  endtask

  // Drain all outstanding results, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // One command; start stays high through a burst, drops for gaps and at phase end
  task automatic send_cmd(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y,
                          input logic signed [IN_W-1:0] z, input bit last);
    start    <= 1'b1;
    vel_fwd  <= x;
    vel_lat  <= y;
    yaw_rate <= z;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 || last) begin
      start    <= 1'b0;
      vel_fwd  <= IN_W'($urandom);
      vel_lat  <= IN_W'($urandom);
      yaw_rate <= IN_W'($urandom);
    end
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
  endtask

  // Mostly full range, with small values, deadband edges and extremes mixed in
  function automatic logic signed [IN_W-1:0] pick_velocity(input int db);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = int'($urandom_range(0, 65535)) - 32768;
      5, 6: v = int'($urandom_range(0, 1024)) - 512;
      7: begin
        v = db + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      8: begin
        case ($urandom_range(0, 3))
          0: v = 32767;
          1: v = -32768;
          2: v = -32767;
          default: v = 1;
        endcase
      end
      default: v = 0;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return IN_W'(v);
  endfunction

  // 16-bit register value: mostly typical, sometimes an extreme
  function automatic logic [15:0] pick16(input int typical_hi);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, typical_hi));
    endcase
  endfunction

  function automatic chassis_cfg_t random_cfg();
    chassis_cfg_t            c;
    logic signed [SPD_W-1:0] a;
    logic signed [SPD_W-1:0] b;
    c.mode     = mode_e'($urandom_range(0, 3));
    c.base     = pick16(16384);
    c.track    = pick16(16384);
    c.inv_circ = pick16(4096);
    c.inv_rad  = pick16(4096);
    a          = SPD_W'($urandom);
    b          = SPD_W'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        c.max_spd = RST_MAX_SPEED;
        c.min_spd = RST_MIN_SPEED;
      end
      1: begin
        c.max_spd = (a > b) ? a : b;
        c.min_spd = (a > b) ? b : a;
      end
      2: begin
        c.max_spd = SPD_W'($urandom_range(0, 4000));
        c.min_spd = -SPD_W'($urandom_range(0, 4000));
      end
      default: begin
        // independent bounds, often inverted
        c.max_spd = a;
        c.min_spd = b;
      end
    endcase
    case ($urandom_range(0, 5))
      0: c.db = '0;
      1: c.db = 15'h7FFF;
      2: c.db = DB_W'($urandom_range(0, 32767));
      default: c.db = DB_W'($urandom_range(0, 64));
    endcase
    return c;
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    burst_left = $urandom_range(1, 10);

    // Reset setup: mecanum, zero geometry, deadband of 4
    send_cmd(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_cmd(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_cmd(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    send_cmd(16'sd3, -16'sd3, 16'sd4, 1'b0);
    send_cmd(-16'sd4, 16'sd5, -16'sd5, 1'b0);
    send_cmd(16'sd32767, -16'sd32768, 16'sd4096, 1'b1);
    wait_idle();

    // Differential, largest geometry and reciprocals, deadband at its top
    cfg = '{MODE_DIFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            RST_MAX_SPEED, RST_MIN_SPEED, 15'h7FFF};
    apply_cfg(cfg);
    send_cmd(-16'sd32768, 16'sd32767, -16'sd32768, 1'b0);
    send_cmd(16'sd32767, 16'sd32766, 16'sd32767, 1'b0);
    send_cmd(-16'sd32767, -16'sd32766, 16'sd1, 1'b1);
    wait_idle();

    // Four-wheel standard with a zero reciprocal: all speeds zero
    cfg = '{MODE_STANDARD, 16'd4915, 16'd6553, 16'd0, 16'd0,
            RST_MAX_SPEED, RST_MIN_SPEED, 15'd0};
    apply_cfg(cfg);
    send_cmd(16'sd32767, -16'sd32768, 16'sd12000, 1'b0);
    send_cmd(-16'sd4096, 16'sd4096, -16'sd32768, 1'b1);
    wait_idle();

    // Mode 3 as mecanum, with inverted speed limits
    cfg = '{MODE_ALT_MEC, 16'd4915, 16'd6553, 16'd818, 16'd5120,
            -16'sd100, 16'sd100, 15'd4};
    apply_cfg(cfg);
    send_cmd(16'sd4096, -16'sd2048, 16'sd1024, 1'b0);
    send_cmd(-16'sd32768, 16'sd0, 16'sd0, 1'b0);
    send_cmd(16'sd0, 16'sd0, 16'sd0, 1'b1);
    wait_idle();

    // Random register settings, random commands
    for (int p = 0; p < RAND_PHASES; p++) begin
      apply_cfg(random_cfg());
      for (int n = 0; n < PHASE_CMDS; n++) begin
        send_cmd(pick_velocity(cur_db), pick_velocity(cur_db), pick_velocity(cur_db),
                 n == PHASE_CMDS - 1);
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
